/* hw/rtl/aolq_pkg.sv */
// shared types and codes for the a-star open list queue
package aolq_pkg;

	// fixed field widths
	localparam int COST_BITS   = 16;
	localparam int OPCODE_BITS = 2;
	localparam int STATUS_BITS = 2;

	// opcodes
	localparam logic [OPCODE_BITS-1:0] OP_PUSH   = 2'd0;
	localparam logic [OPCODE_BITS-1:0] OP_POP    = 2'd1;
	localparam logic [OPCODE_BITS-1:0] OP_UPDATE = 2'd2;

	// status codes
	localparam logic [STATUS_BITS-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_POP_EMPTY   = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_PUSH_FULL   = 2'd2;
	localparam logic [STATUS_BITS-1:0] ST_ID_ABSENT   = 2'd3;

	// register indexes
	localparam logic REG_TARGET_X = 1'b0;
	localparam logic REG_TARGET_Y = 1'b1;

	// per-cell control for one cycle
	typedef struct packed {
		logic insert_en;  // sorted insert of the broadcast word
		logic remove_en;  // take the right neighbor's word
	} cell_ctrl_t;

endpackage

/* hw/rtl/aolq_cell.sv */
// one cell of the sorted chain: holds one key/id word
module aolq_cell
	import aolq_pkg::*;
#(
	parameter int KEY_BITS = 17,
	parameter int ID_BITS  = 16
) (
	input  logic                clk,
	input  cell_ctrl_t          ctrl,
	input  logic                occupied,
	input  logic [KEY_BITS-1:0] new_key,
	input  logic [ID_BITS-1:0]  new_id,
	input  logic [KEY_BITS-1:0] left_key,
	input  logic [ID_BITS-1:0]  left_id,
	input  logic                left_lt,
	input  logic [KEY_BITS-1:0] right_key,
	input  logic [ID_BITS-1:0]  right_id,
	output logic [KEY_BITS-1:0] key,
	output logic [ID_BITS-1:0]  id,
	output logic                lt,
	output logic                match
);

	logic [KEY_BITS-1:0] key_q;
	logic [ID_BITS-1:0]  id_q;

	// compare against the broadcast word
	assign lt    = occupied && (key_q < new_key);
	assign match = occupied && (id_q == new_id);
	assign key   = key_q;
	assign id    = id_q;

	// stay, take the new word, or shift from a neighbor
	always_ff @(posedge clk) begin
		if (ctrl.insert_en && !lt) begin
			if (left_lt) begin
				key_q <= new_key;
				id_q  <= new_id;
			end else begin
				key_q <= left_key;
				id_q  <= left_id;
			end
		end else if (ctrl.remove_en) begin
			key_q <= right_key;
			id_q  <= right_id;
		end
	end

endmodule

/* hw/rtl/aolq_prefix_or.sv */
// parallel prefix or over the cell match flags (inclusive)
module aolq_prefix_or #(
	parameter int WIDTH = 64
) (
	input  logic [WIDTH-1:0] bits,
	output logic [WIDTH-1:0] prefix
);

	localparam int LEVELS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	logic [WIDTH-1:0] lvl [0:LEVELS];

	assign lvl[0] = bits;

	// log-depth combine, span doubles per level
	for (genvar l = 0; l < LEVELS; l++) begin : g_level
		for (genvar i = 0; i < WIDTH; i++) begin : g_bit
			if (i >= (1 << l)) begin : g_join
				assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1<<l)];
			end else begin : g_pass
				assign lvl[l+1][i] = lvl[l][i];
			end
		end
	end

	assign prefix = lvl[LEVELS];

endmodule

/* hw/rtl/astar_open_list_queue_core.sv */
// a-star open list: sorted chain of cells, smallest key at cell zero
// sequencing: push, pop and failed ops give done from the exec phase; a successful update
//   passes the exec phase and then the insert phase before done
// one word at a time: busy holds off start until the previous word's phases are through
// reset: arst_n clears the count, targets and control; the cell contents are not cleared
// the receiver cannot stall: done is high for exactly one cycle per word
module astar_open_list_queue_core
	import aolq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64,
	parameter int COORD_BITS  = 10,
	parameter int ID_BITS     = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	// command side
	input  logic                               start,
	output logic                               busy,
	input  logic [OPCODE_BITS-1:0]             opcode,
	input  logic [ID_BITS-1:0]                 tile_id,
	input  logic [COORD_BITS-1:0]              tile_x,
	input  logic [COORD_BITS-1:0]              tile_y,
	input  logic [COST_BITS-1:0]               path_cost,
	// result side
	output logic                               done,
	output logic [STATUS_BITS-1:0]             status,
	output logic [ID_BITS-1:0]                 popped_id,
	output logic                               front_valid,
	output logic [ID_BITS-1:0]                 front_id,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]   occupancy
);

	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam int KEY_BITS = ((COORD_BITS + 1 > COST_BITS) ? COORD_BITS + 1 : COST_BITS) + 1;

	// sequencer phases
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_EXEC   = 2'd1;
	localparam logic [1:0] PH_INSERT = 2'd2;

	logic [1:0]             phase_q;
	logic [COORD_BITS-1:0]  target_x_q;
	logic [COORD_BITS-1:0]  target_y_q;
	logic [CNT_BITS-1:0]    count_q;
	logic [OPCODE_BITS-1:0] op_q;
	logic [ID_BITS-1:0]     id_q;
	logic [KEY_BITS-1:0]    key_q;
	logic                   done_q;
	logic [STATUS_BITS-1:0] status_q;
	logic [ID_BITS-1:0]     popped_q;

	logic                   accept;
	logic                   cfg_write;
	logic [COORD_BITS-1:0]  dx;
	logic [COORD_BITS-1:0]  dy;
	logic [KEY_BITS-1:0]    new_key;
	logic                   full;
	logic                   empty;
	logic                   found;

	logic [KEY_BITS-1:0]    cell_key [QUEUE_DEPTH];
	logic [ID_BITS-1:0]     cell_id  [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] cell_lt;
	logic [QUEUE_DEPTH-1:0] cell_match;
	logic [QUEUE_DEPTH-1:0] match_seen;
	cell_ctrl_t             cell_ctrl [QUEUE_DEPTH];

	// configuration registers
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q <= '0;
			target_y_q <= '0;
		end else if (cfg_write) begin
			if (paddr[2] == REG_TARGET_X)
				target_x_q <= pwdata[COORD_BITS-1:0];
			else
				target_y_q <= pwdata[COORD_BITS-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_TARGET_X) ? 32'(target_x_q) : 32'(target_y_q);

	// key: cost plus manhattan distance to the target
	assign dx      = (tile_x > target_x_q) ? tile_x - target_x_q : target_x_q - tile_x;
	assign dy      = (tile_y > target_y_q) ? tile_y - target_y_q : target_y_q - tile_y;
	assign new_key = KEY_BITS'(path_cost) + KEY_BITS'(dx) + KEY_BITS'(dy);

	assign busy   = (phase_q != PH_IDLE);
	assign accept = start && !busy;
	assign full   = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign found  = match_seen[QUEUE_DEPTH-1];

	// first match from the front
	aolq_prefix_or #(
		.WIDTH(QUEUE_DEPTH)
	) u_prefix (
		.bits   (cell_match),
		.prefix (match_seen)
	);

	// per-cell control
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			cell_ctrl[i].insert_en = ((phase_q == PH_EXEC) && (op_q == OP_PUSH) && !full) ||
			                         (phase_q == PH_INSERT);
			cell_ctrl[i].remove_en = (phase_q == PH_EXEC) &&
			                         (((op_q == OP_POP) && !empty) ||
			                          ((op_q == OP_UPDATE) && match_seen[i]));
		end
	end

	// the cell chain
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [KEY_BITS-1:0] l_key;
		logic [ID_BITS-1:0]  l_id;
		logic                l_lt;
		logic [KEY_BITS-1:0] r_key;
		logic [ID_BITS-1:0]  r_id;

		if (i == 0) begin : g_head
			assign l_key = key_q;
			assign l_id  = id_q;
			assign l_lt  = 1'b1;
		end else begin : g_body
			assign l_key = cell_key[i-1];
			assign l_id  = cell_id[i-1];
			assign l_lt  = cell_lt[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign r_key = cell_key[i];
			assign r_id  = cell_id[i];
		end else begin : g_inner
			assign r_key = cell_key[i+1];
			assign r_id  = cell_id[i+1];
		end

		aolq_cell #(
			.KEY_BITS(KEY_BITS),
			.ID_BITS (ID_BITS)
		) u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl[i]),
			.occupied  (CNT_BITS'(i) < count_q),
			.new_key   (key_q),
			.new_id    (id_q),
			.left_key  (l_key),
			.left_id   (l_id),
			.left_lt   (l_lt),
			.right_key (r_key),
			.right_id  (r_id),
			.key       (cell_key[i]),
			.id        (cell_id[i]),
			.lt        (cell_lt[i]),
			.match     (cell_match[i])
		);
	end

	// command word capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode;
			id_q  <= tile_id;
			key_q <= new_key;
		end
	end

	// sequencer, count and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (accept)
						phase_q <= PH_EXEC;
				end
				PH_EXEC: begin
					phase_q <= PH_IDLE;
					done_q  <= 1'b1;
					case (op_q)
						OP_PUSH: begin
							if (!full)
								count_q <= count_q + CNT_BITS'(1);
						end
						OP_POP: begin
							if (!empty)
								count_q <= count_q - CNT_BITS'(1);
						end
						OP_UPDATE: begin
							if (found) begin
								count_q <= count_q - CNT_BITS'(1);
								phase_q <= PH_INSERT;
								done_q  <= 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
				PH_INSERT: begin
					count_q <= count_q + CNT_BITS'(1);
					phase_q <= PH_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	// status and popped id
	always_ff @(posedge clk) begin
		if (phase_q == PH_EXEC) begin
			status_q <= ST_OK;
			popped_q <= '0;
			case (op_q)
				OP_PUSH: begin
					if (full)
						status_q <= ST_PUSH_FULL;
				end
				OP_POP: begin
					if (empty)
						status_q <= ST_POP_EMPTY;
					else
						popped_q <= cell_id[0];
				end
				OP_UPDATE: begin
					if (!found)
						status_q <= ST_ID_ABSENT;
				end
				default: begin
				end
			endcase
		end
	end

	// result ports
	assign done        = done_q;
	assign status      = status_q;
	assign popped_id   = popped_q;
	assign front_valid = !empty;
	assign front_id    = empty ? '0 : cell_id[0];
	assign occupancy   = count_q;

endmodule

/* dv/tb_astar_open_list_queue_core.sv */
// testbench for the a-star open list queue core against a sorted-list predictor
module tb_astar_open_list_queue_core;
	import aolq_pkg::*;

	localparam int QUEUE_DEPTH = 64;
	localparam int COORD_BITS  = 10;
	localparam int ID_BITS     = 16;
	localparam int OCC_BITS    = $clog2(QUEUE_DEPTH + 1);
	localparam int KEY_BITS    = 17;
	localparam int IDLE_LIMIT  = 2000;
	localparam int PHASE_WORDS = 210;
	localparam int MAX_SHOWN   = 10;
	localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;
	localparam logic [COORD_BITS-1:0]  COORD_MAX = '1;

	typedef struct packed {
		logic [OPCODE_BITS-1:0] opcode;
		logic [ID_BITS-1:0]     id;
		logic [COORD_BITS-1:0]  x;
		logic [COORD_BITS-1:0]  y;
		logic [COST_BITS-1:0]   cost;
	} tile_cmd_t;

	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		logic [ID_BITS-1:0]     popped;
		logic                   front_valid;
		logic [ID_BITS-1:0]     front;
		logic [OCC_BITS-1:0]    occ;
	} open_list_result_t;

	// block ports
	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [2:0]             paddr = '0;
	logic [31:0]            pwdata = '0;
	logic [31:0]            prdata;
	logic                   pready;
	logic                   start = 1'b0;
	logic                   busy;
	logic [OPCODE_BITS-1:0] opcode = '0;
	logic [ID_BITS-1:0]     tile_id = '0;
	logic [COORD_BITS-1:0]  tile_x = '0;
	logic [COORD_BITS-1:0]  tile_y = '0;
	logic [COST_BITS-1:0]   path_cost = '0;
	logic                   done;
	logic [STATUS_BITS-1:0] status;
	logic [ID_BITS-1:0]     popped_id;
	logic                   front_valid;
	logic [ID_BITS-1:0]     front_id;
	logic [OCC_BITS-1:0]    occupancy;

	// predictor state
	logic [KEY_BITS-1:0]   open_keys [QUEUE_DEPTH];
	logic [ID_BITS-1:0]    open_ids [QUEUE_DEPTH];
	int                    open_count = 0;
	logic [COORD_BITS-1:0] aim_x = '0;
	logic [COORD_BITS-1:0] aim_y = '0;

	// traffic bookkeeping
	tile_cmd_t         cmd_pending [$];
	open_list_result_t expected_results [$];
	tile_cmd_t         drive_cmd;
	open_list_result_t got_res;
	open_list_result_t want_res;
	logic              took_word = 1'b0;
	logic              no_gaps = 1'b1;
	int                gap_left = 0;
	int                mismatches = 0;
	int                idle_cycles = 0;

	astar_open_list_queue_core #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.COORD_BITS (COORD_BITS),
		.ID_BITS    (ID_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.tile_id    (tile_id),
		.tile_x     (tile_x),
		.tile_y     (tile_y),
		.path_cost  (path_cost),
		.done       (done),
		.status     (status),
		.popped_id  (popped_id),
		.front_valid(front_valid),
		.front_id   (front_id),
		.occupancy  (occupancy)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// cost plus manhattan distance to the target tile
	function automatic logic [KEY_BITS-1:0] tile_key(tile_cmd_t c);
		int dx;
		int dy;
		dx = (c.x > aim_x) ? int'(c.x) - int'(aim_x) : int'(aim_x) - int'(c.x);
		dy = (c.y > aim_y) ? int'(c.y) - int'(aim_y) : int'(aim_y) - int'(c.y);
		return KEY_BITS'(int'(c.cost) + dx + dy);
	endfunction

	// new entry goes ahead of the first entry with an equal or larger key
	function automatic void sorted_insert(logic [KEY_BITS-1:0] key, logic [ID_BITS-1:0] id);
		int pos;
		pos = 0;
		while (pos < open_count && open_keys[pos] < key)
			pos++;
		for (int i = open_count; i > pos; i--) begin
			open_keys[i] = open_keys[i-1];
			open_ids[i]  = open_ids[i-1];
		end
		open_keys[pos] = key;
		open_ids[pos]  = id;
		open_count++;
	endfunction

	function automatic void remove_entry(int pos);
		for (int i = pos; i < open_count - 1; i++) begin
			open_keys[i] = open_keys[i+1];
			open_ids[i]  = open_ids[i+1];
		end
		open_count--;
	endfunction

	// apply one word to the predicted open list and form its result
	function automatic open_list_result_t open_list_step(tile_cmd_t c);
		open_list_result_t r;
		int pos;
		r = '0;
		r.status = ST_OK;
		case (c.opcode)
			OP_PUSH: begin
				if (open_count >= QUEUE_DEPTH)
					r.status = ST_PUSH_FULL;
				else
					sorted_insert(tile_key(c), c.id);
			end
			OP_POP: begin
				if (open_count == 0) begin
					r.status = ST_POP_EMPTY;
				end else begin
					r.popped = open_ids[0];
					remove_entry(0);
				end
			end
			OP_UPDATE: begin
				pos = 0;
				while (pos < open_count && open_ids[pos] != c.id)
					pos++;
				if (pos >= open_count) begin
					r.status = ST_ID_ABSENT;
				end else begin
					remove_entry(pos);
					sorted_insert(tile_key(c), c.id);
				end
			end
			default: begin
			end
		endcase
		r.front_valid = (open_count > 0);
		r.front       = (open_count > 0) ? open_ids[0] : '0;
		r.occ         = OCC_BITS'(open_count);
		return r;
	endfunction

	// idle gap after a word: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic tile_cmd_t make_cmd(logic [OPCODE_BITS-1:0] op, logic [ID_BITS-1:0] id,
			logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y, logic [COST_BITS-1:0] cost);
		tile_cmd_t c;
		c.opcode = op;
		c.id     = id;
		c.x      = x;
		c.y      = y;
		c.cost   = cost;
		return c;
	endfunction

	// append a word to the driver queue
	function automatic void queue_cmd(tile_cmd_t c);
		cmd_pending.insert(cmd_pending.size(), c);
	endfunction

	function automatic logic [COORD_BITS-1:0] rand_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		else if (r == 1)
			return COORD_MAX;
		return COORD_BITS'($urandom_range(0, 1023));
	endfunction

	// random word with a given push and pop mix; ids mostly from a small pool
	function automatic tile_cmd_t rand_cmd(int push_pct, int pop_pct);
		tile_cmd_t c;
		int r;
		r = $urandom_range(0, 99);
		if (r < push_pct)
			c.opcode = OP_PUSH;
		else if (r < push_pct + pop_pct)
			c.opcode = OP_POP;
		else if (r < 99)
			c.opcode = OP_UPDATE;
		else
			c.opcode = OP_UNUSED;
		c.id = ($urandom_range(0, 3) != 0) ? ID_BITS'($urandom_range(0, 47)) : ID_BITS'($urandom);
		c.x  = rand_coord();
		c.y  = rand_coord();
		r = $urandom_range(0, 9);
		if (r < 4)
			c.cost = COST_BITS'($urandom_range(0, 255));
		else if (r == 4)
			c.cost = '0;
		else if (r == 5)
			c.cost = '1;
		else
			c.cost = COST_BITS'($urandom);
		return c;
	endfunction

	// register write with a setup phase and an access phase, then the predictor copy follows
	task automatic write_target(logic idx, logic [COORD_BITS-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= {22'($urandom), val};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx == REG_TARGET_X)
			aim_x = val;
		else
			aim_y = val;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// hold until every queued word is taken and every result is back
	task automatic wait_drained();
		@(negedge clk);
		while (cmd_pending.size() != 0 || start || busy || expected_results.size() != 0)
			@(negedge clk);
	endtask

	// driver: one command word per start/busy handshake
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !took_word) begin
			// word still waiting for the core
		end else if (gap_left > 0) begin
			start    <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (cmd_pending.size() != 0) begin
			drive_cmd = cmd_pending[0];
			cmd_pending.delete(0);
			start     <= 1'b1;
			opcode    <= drive_cmd.opcode;
			tile_id   <= drive_cmd.id;
			tile_x    <= drive_cmd.x;
			tile_y    <= drive_cmd.y;
			path_cost <= drive_cmd.cost;
			gap_left  <= no_gaps ? 0 : pick_gap();
		end else begin
			start <= 1'b0;
		end
	end

	// monitor: check results, predict accepted words, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			took_word <= start && !busy;
			if (done) begin
				got_res.status      = status;
				got_res.popped      = popped_id;
				got_res.front_valid = front_valid;
				got_res.front       = front_id;
				got_res.occ         = occupancy;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("unexpected word: status %0d popped %0h front %0d/%0h occ %0d",
							got_res.status, got_res.popped, got_res.front_valid, got_res.front,
							got_res.occ);
				end else begin
					want_res = expected_results[0];
					expected_results.delete(0);
					if (got_res !== want_res) begin
						mismatches++;
						if (mismatches <= MAX_SHOWN) begin
							$display("result mismatch: exp status %0d popped %0h front %0d/%0h occ %0d",
								want_res.status, want_res.popped, want_res.front_valid,
								want_res.front, want_res.occ);
							$display("                 got status %0d popped %0h front %0d/%0h occ %0d",
								got_res.status, got_res.popped, got_res.front_valid,
								got_res.front, got_res.occ);
						end
					end
				end
			end
			if (start && !busy)
				expected_results.insert(expected_results.size(),
					open_list_step(make_cmd(opcode, tile_id, tile_x, tile_y, path_cost)));
			if (done || (start && !busy) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// stimulus sequence
	initial begin
		int push_mix [8] = '{70, 40, 50, 75, 30, 55, 45, 20};
		int pop_mix [8]  = '{15, 45, 25, 10, 55, 25, 30, 65};
		logic [COORD_BITS-1:0] tx_set [8] = '{10'd0, 10'd1023, 10'd0, 10'd1023, 10'd512,
			10'd3, 10'd1000, 10'd77};
		logic [COORD_BITS-1:0] ty_set [8] = '{10'd0, 10'd1023, 10'd1023, 10'd0, 10'd9,
			10'd700, 10'd1, 10'd301};

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed: asymmetric target so a swapped heuristic axis shows
		write_target(REG_TARGET_X, 10'd5);
		write_target(REG_TARGET_Y, 10'd1000);
		no_gaps = 1'b0;
		queue_cmd(make_cmd(OP_POP, 16'd0, 10'd0, 10'd0, 16'd0));
		queue_cmd(make_cmd(OP_UPDATE, 16'd7, 10'd5, 10'd1000, 16'd3));
		queue_cmd(make_cmd(OP_PUSH, 16'hFFFF, COORD_MAX, COORD_MAX, 16'hFFFF));
		queue_cmd(make_cmd(OP_PUSH, 16'd0, 10'd0, 10'd0, 16'd0));
		queue_cmd(make_cmd(OP_PUSH, 16'd7, 10'd5, 10'd1000, 16'd10));
		// equal key: newest one goes first
		queue_cmd(make_cmd(OP_PUSH, 16'd8, 10'd5, 10'd1000, 16'd10));
		// duplicate id further back
		queue_cmd(make_cmd(OP_PUSH, 16'd7, 10'd6, 10'd1000, 16'd100));
		queue_cmd(make_cmd(OP_UPDATE, 16'd7, 10'd5, 10'd1000, 16'd20));
		queue_cmd(make_cmd(OP_UNUSED, 16'hFFFF, COORD_MAX, COORD_MAX, 16'hFFFF));
		queue_cmd(make_cmd(OP_UPDATE, 16'hFFFF, 10'd5, 10'd1000, 16'd0));
		queue_cmd(make_cmd(OP_UPDATE, 16'h1234, 10'd0, 10'd0, 16'd0));
		queue_cmd(make_cmd(OP_PUSH, 16'hAAAA, 10'h2AA, 10'h155, 16'h5555));
		queue_cmd(make_cmd(OP_PUSH, 16'h5555, 10'h155, 10'h2AA, 16'hAAAA));
		for (int i = 0; i < 8; i++)
			queue_cmd(make_cmd(OP_POP, 16'd0, 10'd0, 10'd0, 16'd0));
		wait_drained();

		// random phases, each under its own target
		for (int p = 0; p < 8; p++) begin
			if (p == 4) begin
				tx_set[p] = COORD_BITS'($urandom);
				ty_set[p] = COORD_BITS'($urandom);
			end
			write_target(REG_TARGET_X, tx_set[p]);
			write_target(REG_TARGET_Y, ty_set[p]);
			no_gaps = (p % 3 == 0);
			for (int i = 0; i < PHASE_WORDS; i++)
				queue_cmd(rand_cmd(push_mix[p], pop_mix[p]));
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* astar_open_list_queue_core.f */
hw/rtl/aolq_pkg.sv
hw/rtl/aolq_cell.sv
hw/rtl/aolq_prefix_or.sv
hw/rtl/astar_open_list_queue_core.sv
dv/tb_astar_open_list_queue_core.sv
